>>> src/arc_pkg.sv
// Shared types, constants and widths of the ARP resolver cache.
package arc_pkg;

  localparam int CACHE_ENTRIES = 16;
  localparam int PENDING_DEPTH = 16;

  localparam int CIDX_W = (CACHE_ENTRIES > 1) ? $clog2(CACHE_ENTRIES) : 1;
  localparam int PIDX_W = (PENDING_DEPTH > 1) ? $clog2(PENDING_DEPTH) : 1;
  localparam int PCNT_W = $clog2(PENDING_DEPTH + 1);

  localparam int IN_TDATA_W  = 296;
  localparam int OUT_TDATA_W = 152;

  localparam logic [47:0] MAC_BCAST    = 48'hFFFF_FFFF_FFFF;
  localparam logic [31:0] RST_LIFETIME = 32'd30000;
  localparam logic [31:0] RST_HOLDOFF  = 32'd5000;

  localparam logic [1:0] ARP_OP_NONE    = 2'd0;
  localparam logic [1:0] ARP_OP_REQUEST = 2'd1;
  localparam logic [1:0] ARP_OP_REPLY   = 2'd2;

  typedef enum logic [1:0] {
    CMD_SEND = 2'd0,
    CMD_ARP  = 2'd1,
    CMD_IPV4 = 2'd2,
    CMD_TICK = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    KIND_IPV4    = 2'd0,
    KIND_ARP     = 2'd1,
    KIND_DELIVER = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    CFG_OWN_MAC  = 2'd0,
    CFG_OWN_IP   = 2'd1,
    CFG_LIFETIME = 2'd2,
    CFG_HOLDOFF  = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    kind_t       kind;
    logic [47:0] dst_mac;
    logic [1:0]  arp_op;
    logic [31:0] target_ip;
    logic [47:0] target_mac;
    logic [15:0] handle;
  } res_t;

  typedef struct packed {
    logic vld;
    logic fin;
    res_t res;
  } emit_req_t;

  typedef struct packed {
    logic [31:0] ip;
    logic [47:0] mac;
    logic [63:0] expiry;
  } cent_t;

  typedef struct packed {
    logic [31:0] ip;
    logic [63:0] hold_end;
  } hent_t;

  typedef struct packed {
    cent_t c;
    hent_t h;
  } tbl_ent_t;

  typedef struct packed {
    logic [31:0] ip;
    logic [15:0] handle;
  } pent_t;

endpackage

>>> src/arc_ram.sv
// Simple dual-port synchronous RAM with bit write mask and registered read data.
module arc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [WIDTH-1:0]                       wmask,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= (mem[waddr] & ~wmask) | (wdata & wmask);
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> src/arc_emit.sv
// Result stash and output register; marks the final result of an item.
module arc_emit import arc_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  emit_req_t req,
  output logic      rdy,
  output logic      out_vld,
  input  logic      out_rdy,
  output res_t      out_res,
  output logic      out_last
);

  logic out_vld_r, out_vld_nxt;
  logic out_last_r, out_last_nxt;
  res_t out_res_r, out_res_nxt;
  logic stash_vld_r, stash_vld_nxt;
  res_t stash_r, stash_nxt;

  assign rdy      = !out_vld_r || out_rdy;
  assign out_vld  = out_vld_r;
  assign out_res  = out_res_r;
  assign out_last = out_last_r;

  always_comb begin
    out_vld_nxt   = out_vld_r && !out_rdy;
    out_last_nxt  = out_last_r;
    out_res_nxt   = out_res_r;
    stash_vld_nxt = stash_vld_r;
    stash_nxt     = stash_r;
    priority if (req.vld && rdy) begin
      if (stash_vld_r) begin
        out_vld_nxt  = 1'b1;
        out_res_nxt  = stash_r;
        out_last_nxt = 1'b0;
      end
      stash_nxt     = req.res;
      stash_vld_nxt = 1'b1;
    end else if (req.fin && rdy && stash_vld_r) begin
      out_vld_nxt   = 1'b1;
      out_res_nxt   = stash_r;
      out_last_nxt  = 1'b1;
      stash_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r   <= 1'b0;
      stash_vld_r <= 1'b0;
    end else begin
      out_vld_r   <= out_vld_nxt;
      stash_vld_r <= stash_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_res_r  <= out_res_nxt;
    out_last_r <= out_last_nxt;
    stash_r    <= stash_nxt;
  end

endmodule

>>> src/arp_resolver_cache.sv
// Top level of the ARP resolver cache: control sequencer, tables and stream ports.
//
// Usage:
//   in_*  : one event per item; in_tuser is the command (send, ARP frame received,
//           IPv4 frame received, tick), in_tdata the event fields.
//   out_* : result items; out_tuser is the kind, out_tlast marks the final result
//           of an event. An event may give no result at all.
//   cfg_* : register writes (own MAC, own IP, lifetime, hold-off), one per cycle,
//           always ready; write only while no event is in flight.
// One event is in work at a time. A tick goes straight to the finish state, an IPv4
//   receive through its check and finish. A send and an ARP receive first scan the
//   shared cache and hold-off RAM at one entry per cycle; an ARP receive then reads
//   and checks each queued datagram of the pending queue RAM in turn.
//   A result waits in a stash until the next one of the event is formed or the
//   event ends, then moves to the output register, so the last one can be marked.
// Reset: synchronous, active low; clears valid bits, victim pointers, queue count,
//   time and registers to their defaults. No memory clearing pass is needed.
// Stall: while out_tready is low with a result valid, the result register holds and the
//   sequencer waits in the states that hand over a result or end the event; no result is dropped.
module arp_resolver_cache import arc_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // next_hop_ip, dgram_handle, frame_src_mac, frame_dst_mac, arp_op,
  // arp_sender_ip, arp_sender_mac, arp_target_ip, elapsed_ms, zero pad
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  // cmd
  input  logic [1:0]             in_tuser,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // dst_mac, out_arp_op, out_target_ip, out_target_mac, out_handle, zero pad
  output logic [OUT_TDATA_W-1:0] out_tdata,
  // out_kind
  output logic [1:0]             out_tuser,
  output logic                   out_tlast,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [1:0]             cfg_index,
  input  logic [47:0]            cfg_data
);

  typedef enum logic [7:0] {
    S_IDLE   = 8'b0000_0001,
    S_SCAN   = 8'b0000_0010,
    S_DRAIN  = 8'b0000_0100,
    S_DECIDE = 8'b0000_1000,
    S_PRD    = 8'b0001_0000,
    S_PCHK   = 8'b0010_0000,
    S_RX     = 8'b0100_0000,
    S_FIN    = 8'b1000_0000
  } state_t;

  state_t state_r, state_nxt;

  logic [47:0] own_mac_r, own_mac_nxt;
  logic [31:0] own_ip_r, own_ip_nxt;
  logic [31:0] life_r, life_nxt;
  logic [31:0] hold_ms_r, hold_ms_nxt;
  logic [63:0] now_r, now_nxt;
  logic [CACHE_ENTRIES-1:0] cvalid_r, cvalid_nxt;
  logic [CACHE_ENTRIES-1:0] hvalid_r, hvalid_nxt;
  logic [CIDX_W-1:0] cvict_r, cvict_nxt;
  logic [CIDX_W-1:0] hvict_r, hvict_nxt;
  logic [PCNT_W-1:0] pcount_r, pcount_nxt;
  logic              chk_vld_r, chk_vld_nxt;

  cmd_t        cmd_r, cmd_nxt;
  logic [31:0] nh_r, nh_nxt;
  logic [15:0] hdl_r, hdl_nxt;
  logic [47:0] fsrc_r, fsrc_nxt;
  logic [47:0] fdst_r, fdst_nxt;
  logic [1:0]  op_r, op_nxt;
  logic [31:0] sip_r, sip_nxt;
  logic [47:0] smac_r, smac_nxt;
  logic [31:0] tip_r, tip_nxt;
  logic [CIDX_W-1:0] scan_r, scan_nxt;
  logic [CIDX_W-1:0] chk_idx_r, chk_idx_nxt;
  logic              c_hit_r, c_hit_nxt;
  logic [CIDX_W-1:0] c_idx_r, c_idx_nxt;
  logic [47:0]       c_mac_r, c_mac_nxt;
  logic [63:0]       c_exp_r, c_exp_nxt;
  logic              h_hit_r, h_hit_nxt;
  logic [CIDX_W-1:0] h_idx_r, h_idx_nxt;
  logic [63:0]       h_until_r, h_until_nxt;
  logic [PCNT_W-1:0] j_r, j_nxt;
  logic [PCNT_W-1:0] w_r, w_nxt;

  logic              t_we, t_re, p_we, p_re;
  logic [CIDX_W-1:0] t_waddr, t_raddr;
  logic [PIDX_W-1:0] p_waddr, p_raddr;
  tbl_ent_t          t_wmask, t_wdata, t_rd;
  pent_t             p_wdata, p_rd;

  emit_req_t   emit;
  logic        emit_rdy;
  res_t        out_res;
  logic [31:0] key;

  arc_ram #(.WIDTH($bits(tbl_ent_t)), .DEPTH(CACHE_ENTRIES)) u_tbl_ram (
    .clk(clk), .we(t_we), .wmask(t_wmask), .waddr(t_waddr), .wdata(t_wdata),
    .re(t_re), .raddr(t_raddr), .rdata(t_rd)
  );

  arc_ram #(.WIDTH($bits(pent_t)), .DEPTH(PENDING_DEPTH)) u_pend_ram (
    .clk(clk), .we(p_we), .wmask({$bits(pent_t){1'b1}}), .waddr(p_waddr),
    .wdata(p_wdata), .re(p_re), .raddr(p_raddr), .rdata(p_rd)
  );

  arc_emit u_emit (
    .clk(clk), .rst_n(rst_n), .req(emit), .rdy(emit_rdy),
    .out_vld(out_tvalid), .out_rdy(out_tready), .out_res(out_res), .out_last(out_tlast)
  );

  assign in_tready = (state_r == S_IDLE);
  assign cfg_ready = 1'b1;
  assign out_tuser = out_res.kind;
  assign out_tdata = {6'd0, out_res.handle, out_res.target_mac, out_res.target_ip,
                      out_res.arp_op, out_res.dst_mac};
  assign key       = (cmd_r == CMD_SEND) ? nh_r : sip_r;

  always_comb begin
    state_nxt   = state_r;
    own_mac_nxt = own_mac_r;
    own_ip_nxt  = own_ip_r;
    life_nxt    = life_r;
    hold_ms_nxt = hold_ms_r;
    now_nxt     = now_r;
    cvalid_nxt  = cvalid_r;
    hvalid_nxt  = hvalid_r;
    cvict_nxt   = cvict_r;
    hvict_nxt   = hvict_r;
    pcount_nxt  = pcount_r;
    chk_vld_nxt = chk_vld_r;
    cmd_nxt     = cmd_r;
    nh_nxt      = nh_r;
    hdl_nxt     = hdl_r;
    fsrc_nxt    = fsrc_r;
    fdst_nxt    = fdst_r;
    op_nxt      = op_r;
    sip_nxt     = sip_r;
    smac_nxt    = smac_r;
    tip_nxt     = tip_r;
    scan_nxt    = scan_r;
    chk_idx_nxt = chk_idx_r;
    c_hit_nxt   = c_hit_r;
    c_idx_nxt   = c_idx_r;
    c_mac_nxt   = c_mac_r;
    c_exp_nxt   = c_exp_r;
    h_hit_nxt   = h_hit_r;
    h_idx_nxt   = h_idx_r;
    h_until_nxt = h_until_r;
    j_nxt       = j_r;
    w_nxt       = w_r;
    t_we = 1'b0; t_re = 1'b0; t_waddr = '0; t_raddr = '0; t_wmask = '0; t_wdata = '0;
    p_we = 1'b0; p_re = 1'b0; p_waddr = '0; p_raddr = '0; p_wdata = '0;
    emit = '0;

    if (cfg_valid) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_OWN_MAC:  own_mac_nxt = cfg_data;
        CFG_OWN_IP:   own_ip_nxt  = cfg_data[31:0];
        CFG_LIFETIME: life_nxt    = cfg_data[31:0];
        CFG_HOLDOFF:  hold_ms_nxt = cfg_data[31:0];
      endcase
    end

    // compare the entry read in the previous cycle; keep the first match
    if (chk_vld_r) begin
      if (!c_hit_r && cvalid_r[chk_idx_r] && t_rd.c.ip == key) begin
        c_hit_nxt = 1'b1;
        c_idx_nxt = chk_idx_r;
        c_mac_nxt = t_rd.c.mac;
        c_exp_nxt = t_rd.c.expiry;
      end
      if (!h_hit_r && hvalid_r[chk_idx_r] && t_rd.h.ip == key) begin
        h_hit_nxt   = 1'b1;
        h_idx_nxt   = chk_idx_r;
        h_until_nxt = t_rd.h.hold_end;
      end
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd_nxt   = cmd_t'(in_tuser);
          nh_nxt    = in_tdata[31:0];
          hdl_nxt   = in_tdata[47:32];
          fsrc_nxt  = in_tdata[95:48];
          fdst_nxt  = in_tdata[143:96];
          op_nxt    = in_tdata[145:144];
          sip_nxt   = in_tdata[177:146];
          smac_nxt  = in_tdata[225:178];
          tip_nxt   = in_tdata[257:226];
          scan_nxt  = '0;
          c_hit_nxt = 1'b0;
          h_hit_nxt = 1'b0;
          unique case (cmd_t'(in_tuser))
            CMD_SEND, CMD_ARP: state_nxt = S_SCAN;
            CMD_IPV4:          state_nxt = S_RX;
            CMD_TICK: begin
              now_nxt   = now_r + 64'(in_tdata[289:258]);
              state_nxt = S_FIN;
            end
          endcase
        end
      end
      S_SCAN: begin
        t_re        = 1'b1;
        t_raddr     = scan_r;
        chk_vld_nxt = 1'b1;
        chk_idx_nxt = scan_r;
        if (scan_r == CIDX_W'(CACHE_ENTRIES - 1)) begin
          state_nxt = S_DRAIN;
        end else begin
          scan_nxt = scan_r + 1'b1;
        end
      end
      S_DRAIN: begin
        chk_vld_nxt = 1'b0;
        state_nxt   = S_DECIDE;
      end
      S_DECIDE: begin
        if (emit_rdy) begin
          if (cmd_r == CMD_SEND) begin
            if (c_hit_r && now_r < c_exp_r) begin
              emit.vld            = 1'b1;
              emit.res.kind       = KIND_IPV4;
              emit.res.dst_mac    = c_mac_r;
              emit.res.arp_op     = ARP_OP_NONE;
              emit.res.handle     = hdl_r;
            end else begin
              if (pcount_r < PCNT_W'(PENDING_DEPTH)) begin
                p_we       = 1'b1;
                p_waddr    = pcount_r[PIDX_W-1:0];
                p_wdata    = '{ip: nh_r, handle: hdl_r};
                pcount_nxt = pcount_r + 1'b1;
              end
              if (!h_hit_r || now_r >= h_until_r) begin
                t_we      = 1'b1;
                t_waddr   = h_hit_r ? h_idx_r : hvict_r;
                t_wdata.h = '{ip: nh_r, hold_end: now_r + 64'(hold_ms_r)};
                t_wmask.h = '1;
                hvalid_nxt[t_waddr] = 1'b1;
                if (!h_hit_r) begin
                  hvict_nxt = (hvict_r == CIDX_W'(CACHE_ENTRIES - 1)) ? '0 : hvict_r + 1'b1;
                end
                emit.vld           = 1'b1;
                emit.res.kind      = KIND_ARP;
                emit.res.dst_mac   = MAC_BCAST;
                emit.res.arp_op    = ARP_OP_REQUEST;
                emit.res.target_ip = nh_r;
              end
            end
            state_nxt = S_FIN;
          end else begin
            t_we      = 1'b1;
            t_waddr   = c_hit_r ? c_idx_r : cvict_r;
            t_wdata.c = '{ip: sip_r, mac: smac_r, expiry: now_r + 64'(life_r)};
            t_wmask.c = '1;
            cvalid_nxt[t_waddr] = 1'b1;
            if (!c_hit_r) begin
              cvict_nxt = (cvict_r == CIDX_W'(CACHE_ENTRIES - 1)) ? '0 : cvict_r + 1'b1;
            end
            if (op_r == ARP_OP_REQUEST && tip_r == own_ip_r) begin
              emit.vld            = 1'b1;
              emit.res.kind       = KIND_ARP;
              emit.res.dst_mac    = fsrc_r;
              emit.res.arp_op     = ARP_OP_REPLY;
              emit.res.target_ip  = sip_r;
              emit.res.target_mac = smac_r;
            end
            j_nxt     = '0;
            w_nxt     = '0;
            state_nxt = S_PRD;
          end
        end
      end
      S_PRD: begin
        if (j_r < pcount_r) begin
          p_re      = 1'b1;
          p_raddr   = j_r[PIDX_W-1:0];
          state_nxt = S_PCHK;
        end else begin
          pcount_nxt = w_r;
          state_nxt  = S_FIN;
        end
      end
      S_PCHK: begin
        if (p_rd.ip == sip_r) begin
          if (emit_rdy) begin
            emit.vld         = 1'b1;
            emit.res.kind    = KIND_IPV4;
            emit.res.dst_mac = smac_r;
            emit.res.arp_op  = ARP_OP_NONE;
            emit.res.handle  = p_rd.handle;
            j_nxt            = j_r + 1'b1;
            state_nxt        = S_PRD;
          end
        end else begin
          p_we      = 1'b1;
          p_waddr   = w_r[PIDX_W-1:0];
          p_wdata   = p_rd;
          w_nxt     = w_r + 1'b1;
          j_nxt     = j_r + 1'b1;
          state_nxt = S_PRD;
        end
      end
      S_RX: begin
        if (fdst_r == own_mac_r) begin
          if (emit_rdy) begin
            emit.vld        = 1'b1;
            emit.res.kind   = KIND_DELIVER;
            emit.res.arp_op = ARP_OP_NONE;
            emit.res.handle = hdl_r;
            state_nxt       = S_FIN;
          end
        end else begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        emit.fin = 1'b1;
        if (emit_rdy) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      own_mac_r <= '0;
      own_ip_r  <= '0;
      life_r    <= RST_LIFETIME;
      hold_ms_r <= RST_HOLDOFF;
      now_r     <= '0;
      cvalid_r  <= '0;
      hvalid_r  <= '0;
      cvict_r   <= '0;
      hvict_r   <= '0;
      pcount_r  <= '0;
      chk_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      own_mac_r <= own_mac_nxt;
      own_ip_r  <= own_ip_nxt;
      life_r    <= life_nxt;
      hold_ms_r <= hold_ms_nxt;
      now_r     <= now_nxt;
      cvalid_r  <= cvalid_nxt;
      hvalid_r  <= hvalid_nxt;
      cvict_r   <= cvict_nxt;
      hvict_r   <= hvict_nxt;
      pcount_r  <= pcount_nxt;
      chk_vld_r <= chk_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r     <= cmd_nxt;
    nh_r      <= nh_nxt;
    hdl_r     <= hdl_nxt;
    fsrc_r    <= fsrc_nxt;
    fdst_r    <= fdst_nxt;
    op_r      <= op_nxt;
    sip_r     <= sip_nxt;
    smac_r    <= smac_nxt;
    tip_r     <= tip_nxt;
    scan_r    <= scan_nxt;
    chk_idx_r <= chk_idx_nxt;
    c_hit_r   <= c_hit_nxt;
    c_idx_r   <= c_idx_nxt;
    c_mac_r   <= c_mac_nxt;
    c_exp_r   <= c_exp_nxt;
    h_hit_r   <= h_hit_nxt;
    h_idx_r   <= h_idx_nxt;
    h_until_r <= h_until_nxt;
    j_r       <= j_nxt;
    w_r       <= w_nxt;
  end

endmodule

>>> src/arc_checker.sv
// Port-level checks of the ARP resolver cache, bound to the top level.
module arc_checker import arc_pkg::*; (
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_tvalid,
  input logic                   in_tready,
  input logic                   out_tvalid,
  input logic                   out_tready,
  input logic [OUT_TDATA_W-1:0] out_tdata,
  input logic [1:0]             out_tuser
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result changed");

  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("second item taken while one is in work");

  a_reset_out: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  a_arp_no_handle: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == KIND_ARP |-> out_tdata[145:130] == 16'd0)
    else $error("ARP result carries a handle");

  a_frame_no_arp: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser != KIND_ARP |-> out_tdata[129:48] == 82'd0)
    else $error("non-ARP result carries ARP fields");

endmodule

bind arp_resolver_cache arc_checker u_arc_checker (
  .clk(clk), .rst_n(rst_n), .in_tvalid(in_tvalid), .in_tready(in_tready),
  .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
  .out_tuser(out_tuser)
);

>>> tb/sv/testbench.sv
// Self-checking stream testbench for the ARP resolver cache, with a scoreboard that models the cache.
`timescale 1ns / 1ps

module testbench;
  import arc_pkg::*;

  typedef struct {
    cmd_t        cmd;
    logic [31:0] nh_ip;
    logic [15:0] handle;
    logic [47:0] src_mac;
    logic [47:0] dst_mac;
    logic [1:0]  arp_op;
    logic [31:0] sender_ip;
    logic [47:0] sender_mac;
    logic [31:0] target_ip;
    logic [31:0] elapsed;
  } arp_event_t;

  typedef struct {
    res_t res;
    logic last;
  } arp_result_t;

  class arp_scoreboard;
    logic [47:0] own_mac;
    logic [31:0] own_ip;
    logic [63:0] lifetime;
    logic [63:0] holdoff;
    logic [63:0] now_ms;
    bit          c_valid[CACHE_ENTRIES];
    logic [31:0] c_ip[CACHE_ENTRIES];
    logic [47:0] c_mac[CACHE_ENTRIES];
    logic [63:0] c_expiry[CACHE_ENTRIES];
    int          c_victim;
    bit          h_valid[CACHE_ENTRIES];
    logic [31:0] h_ip[CACHE_ENTRIES];
    logic [63:0] h_until[CACHE_ENTRIES];
    int          h_victim;
    logic [31:0] p_ip[PENDING_DEPTH];
    logic [15:0] p_handle[PENDING_DEPTH];
    int          p_count;
    arp_result_t batch[$];
    arp_result_t expected[$];
    int          errors;

    function new();
      own_mac = '0;
      own_ip = '0;
      lifetime = 64'(RST_LIFETIME);
      holdoff = 64'(RST_HOLDOFF);
      now_ms = '0;
      c_victim = 0;
      h_victim = 0;
      p_count = 0;
      errors = 0;
      foreach (c_valid[i]) begin
        c_valid[i] = 0;
        h_valid[i] = 0;
      end
    endfunction

    task report(string msg);
      $display("%0t mismatch: %s", $time, msg);
      errors++;
    endtask

    function void set_reg(cfg_idx_t idx, logic [47:0] v);
      case (idx)
        CFG_OWN_MAC:  own_mac = v;
        CFG_OWN_IP:   own_ip = v[31:0];
        CFG_LIFETIME: lifetime = {32'd0, v[31:0]};
        default:      holdoff = {32'd0, v[31:0]};
      endcase
    endfunction

    function void add(kind_t k, logic [47:0] dm, logic [1:0] op, logic [31:0] tip,
                      logic [47:0] tmac, logic [15:0] h);
      arp_result_t r;
      r.res.kind = k;
      r.res.dst_mac = dm;
      r.res.arp_op = op;
      r.res.target_ip = tip;
      r.res.target_mac = tmac;
      r.res.handle = h;
      r.last = 0;
      batch.push_back(r);
    endfunction

    function int find_cache(logic [31:0] ip);
      for (int i = 0; i < CACHE_ENTRIES; i++)
        if (c_valid[i] && c_ip[i] == ip) return i;
      return -1;
    endfunction

    function int find_holdoff(logic [31:0] ip);
      for (int i = 0; i < CACHE_ENTRIES; i++)
        if (h_valid[i] && h_ip[i] == ip) return i;
      return -1;
    endfunction

    function void note_event(arp_event_t e);
      int ci;
      int hi;
      int w;
      batch.delete();
      case (e.cmd)
        CMD_SEND: begin
          ci = find_cache(e.nh_ip);
          if (ci >= 0 && now_ms < c_expiry[ci]) begin
            add(KIND_IPV4, c_mac[ci], ARP_OP_NONE, '0, '0, e.handle);
          end else begin
            if (p_count < PENDING_DEPTH) begin
              p_ip[p_count] = e.nh_ip;
              p_handle[p_count] = e.handle;
              p_count++;
            end
            hi = find_holdoff(e.nh_ip);
            if (hi < 0 || now_ms >= h_until[hi]) begin
              if (hi < 0) begin
                hi = h_victim;
                h_victim = (hi + 1) % CACHE_ENTRIES;
                h_valid[hi] = 1;
                h_ip[hi] = e.nh_ip;
              end
              h_until[hi] = now_ms + holdoff;
              add(KIND_ARP, MAC_BCAST, ARP_OP_REQUEST, e.nh_ip, '0, '0);
            end
          end
        end
        CMD_ARP: begin
          ci = find_cache(e.sender_ip);
          if (ci < 0) begin
            ci = c_victim;
            c_victim = (ci + 1) % CACHE_ENTRIES;
            c_valid[ci] = 1;
            c_ip[ci] = e.sender_ip;
          end
          c_mac[ci] = e.sender_mac;
          c_expiry[ci] = now_ms + lifetime;
          if (e.arp_op == ARP_OP_REQUEST && e.target_ip == own_ip)
            add(KIND_ARP, e.src_mac, ARP_OP_REPLY, e.sender_ip, e.sender_mac, '0);
          w = 0;
          for (int j = 0; j < p_count; j++) begin
            if (p_ip[j] == e.sender_ip) begin
              add(KIND_IPV4, e.sender_mac, ARP_OP_NONE, '0, '0, p_handle[j]);
            end else begin
              p_ip[w] = p_ip[j];
              p_handle[w] = p_handle[j];
              w++;
            end
          end
          p_count = w;
        end
        CMD_IPV4: begin
          if (e.dst_mac == own_mac) add(KIND_DELIVER, '0, ARP_OP_NONE, '0, '0, e.handle);
        end
        default: now_ms = now_ms + {32'd0, e.elapsed};
      endcase
      if (batch.size() > 0) batch[batch.size() - 1].last = 1;
      foreach (batch[i]) expected.push_back(batch[i]);
    endfunction

    task check_result(res_t r, logic last);
      arp_result_t x;
      if (expected.size() == 0) begin
        report($sformatf("unexpected result kind %0d handle %h", r.kind, r.handle));
      end else begin
        x = expected.pop_front();
        if (r.kind !== x.res.kind)
          report($sformatf("kind %0d, want %0d", r.kind, x.res.kind));
        if (r.dst_mac !== x.res.dst_mac)
          report($sformatf("dst_mac %h, want %h", r.dst_mac, x.res.dst_mac));
        if (r.arp_op !== x.res.arp_op)
          report($sformatf("arp_op %0d, want %0d", r.arp_op, x.res.arp_op));
        if (r.target_ip !== x.res.target_ip)
          report($sformatf("target_ip %h, want %h", r.target_ip, x.res.target_ip));
        if (r.target_mac !== x.res.target_mac)
          report($sformatf("target_mac %h, want %h", r.target_mac, x.res.target_mac));
        if (r.handle !== x.res.handle)
          report($sformatf("handle %h, want %h", r.handle, x.res.handle));
        if (last !== x.last)
          report($sformatf("last %b, want %b", last, x.last));
      end
    endtask
  endclass

  logic                   clk = 0;
  logic                   rst_n = 0;
  logic                   in_tvalid = 0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;
  logic [1:0]             in_tuser = '0;
  logic                   out_tvalid;
  logic                   out_tready = 0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic [1:0]             out_tuser;
  logic                   out_tlast;
  logic                   cfg_valid = 0;
  logic                   cfg_ready;
  logic [1:0]             cfg_index = '0;
  logic [47:0]            cfg_data = '0;

  arp_scoreboard sb = new();
  int            burst_left = 0;
  logic [31:0]   addr_pool[8];

  arp_resolver_cache u_dut (.*);

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("testbench NOT OK");
    $finish;
  end

  // next_hop_ip, dgram_handle, frame_src_mac, frame_dst_mac, arp_op,
  // arp_sender_ip, arp_sender_mac, arp_target_ip, elapsed_ms, zero pad
  function automatic logic [IN_TDATA_W-1:0] pack_event(arp_event_t e);
    return IN_TDATA_W'({e.elapsed, e.target_ip, e.sender_mac, e.sender_ip, e.arp_op,
                        e.dst_mac, e.src_mac, e.handle, e.nh_ip});
  endfunction

  always @(posedge clk) begin
    res_t r;
    if (rst_n && out_tvalid && out_tready) begin
      r.kind = kind_t'(out_tuser);
      r.dst_mac = out_tdata[47:0];
      r.arp_op = out_tdata[49:48];
      r.target_ip = out_tdata[81:50];
      r.target_mac = out_tdata[129:82];
      r.handle = out_tdata[145:130];
      sb.check_result(r, out_tlast);
    end
  end

  // receiver: out_tready follows a stall mode that is picked anew at random
  initial begin
    int mode;
    int cyc;
    mode = 0;
    cyc = 0;
    forever begin
      @(negedge clk);
      if (cyc % 64 == 0) mode = $urandom_range(0, 3);
      case (mode)
        0: out_tready = 1'b1;
        1: out_tready = 1'($urandom_range(0, 1));
        2: out_tready = (cyc % 4 == 0);
        default: out_tready = ((cyc / 8) % 2 == 0);
      endcase
      cyc++;
    end
  end

  task automatic write_reg(cfg_idx_t idx, logic [47:0] v);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = v;
    do @(posedge clk); while (!cfg_ready);
    sb.set_reg(idx, v);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic send_event(arp_event_t e);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 12);
      if (gap > 0) begin
        @(negedge clk);
        in_tvalid = 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    @(negedge clk);
    in_tvalid = 1'b1;
    in_tuser = e.cmd;
    in_tdata = pack_event(e);
    do @(posedge clk); while (!in_tready);
    sb.note_event(e);
    burst_left--;
  endtask

  task automatic drain();
    @(negedge clk);
    in_tvalid = 1'b0;
    burst_left = 0;
    while (sb.expected.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  function automatic arp_event_t blank_event(cmd_t c);
    arp_event_t e;
    e.cmd = c;
    e.nh_ip = $urandom;
    e.handle = 16'($urandom);
    e.src_mac = 48'({$urandom, $urandom});
    e.dst_mac = 48'({$urandom, $urandom});
    e.arp_op = 2'($urandom_range(1, 2));
    e.sender_ip = $urandom;
    e.sender_mac = 48'({$urandom, $urandom});
    e.target_ip = $urandom;
    e.elapsed = $urandom;
    return e;
  endfunction

  function automatic arp_event_t random_event();
    arp_event_t e;
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 40) begin
      e = blank_event(CMD_SEND);
      if ($urandom_range(0, 99) < 85) e.nh_ip = addr_pool[$urandom_range(0, 7)];
    end else if (pick < 65) begin
      e = blank_event(CMD_ARP);
      if ($urandom_range(0, 99) < 85) e.sender_ip = addr_pool[$urandom_range(0, 7)];
      if ($urandom_range(0, 1)) e.target_ip = sb.own_ip;
      if ($urandom_range(0, 19) == 0) e.arp_op = 2'($urandom_range(0, 3));
    end else if (pick < 80) begin
      e = blank_event(CMD_IPV4);
      if ($urandom_range(0, 1)) e.dst_mac = sb.own_mac;
    end else begin
      e = blank_event(CMD_TICK);
      if ($urandom_range(0, 9) != 0) e.elapsed = $urandom_range(0, 300);
    end
    return e;
  endfunction

  initial begin
    arp_event_t e;
    logic [31:0] peer;
    logic [31:0] life_set[4];
    logic [31:0] hold_set[4];
    life_set = '{32'd1, 32'hFFFF_FFFF, 32'd200, RST_LIFETIME};
    hold_set = '{32'd1, 32'hFFFF_FFFF, 32'd50, RST_HOLDOFF};
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    write_reg(CFG_OWN_MAC, 48'h02_00_00_AA_BB_CC);
    write_reg(CFG_OWN_IP, 48'h0A_00_00_01);
    write_reg(CFG_LIFETIME, 48'd100);
    write_reg(CFG_HOLDOFF, 48'd50);

    // fill the pending queue for one peer, one more is dropped
    peer = 32'h0A00_0002;
    for (int i = 0; i < PENDING_DEPTH + 1; i++) begin
      e = blank_event(CMD_SEND);
      e.nh_ip = peer;
      e.handle = (i == 0) ? 16'h0000 : (i == 1) ? 16'hFFFF : 16'(i);
      send_event(e);
    end
    // request for our address: reply plus full release
    e = blank_event(CMD_ARP);
    e.arp_op = ARP_OP_REQUEST;
    e.sender_ip = peer;
    e.target_ip = sb.own_ip;
    send_event(e);
    e = blank_event(CMD_SEND);
    e.nh_ip = peer;
    send_event(e);
    e = blank_event(CMD_TICK);
    e.elapsed = 32'hFFFF_FFFF;
    send_event(e);
    e = blank_event(CMD_SEND);
    e.nh_ip = peer;
    send_event(e);
    e = blank_event(CMD_IPV4);
    e.dst_mac = sb.own_mac;
    send_event(e);
    e = blank_event(CMD_IPV4);
    e.dst_mac = ~sb.own_mac;
    send_event(e);
    // odd opcode still teaches and releases
    e = blank_event(CMD_ARP);
    e.arp_op = 2'd3;
    e.sender_ip = peer;
    e.target_ip = sb.own_ip;
    send_event(e);
    e = blank_event(CMD_TICK);
    e.elapsed = '0;
    send_event(e);
    drain();

    for (int ph = 0; ph < 4; ph++) begin
      write_reg(CFG_OWN_MAC, (ph == 1) ? 48'hFFFF_FFFF_FFFF : 48'({$urandom, $urandom}));
      write_reg(CFG_OWN_IP, (ph == 0) ? 48'd0 : (ph == 1) ? 48'hFFFF_FFFF : 48'($urandom));
      write_reg(CFG_LIFETIME, 48'(life_set[ph]));
      write_reg(CFG_HOLDOFF, 48'(hold_set[ph]));
      foreach (addr_pool[i]) addr_pool[i] = $urandom;
      if (ph == 0) addr_pool[0] = '0;
      for (int n = 0; n < 71; n++) begin
        if (ph == 2 && n == 35) begin
          @(negedge clk);
          in_tvalid = 1'b0;
          burst_left = 0;
          while (sb.expected.size() != 0) @(posedge clk);
        end
        send_event(random_event());
      end
      drain();
    end

    if (sb.expected.size() != 0)
      sb.report($sformatf("%0d results never arrived", sb.expected.size()));
    if (sb.errors == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule
